/* src/bmi_pkg.sv */
`timescale 1ns / 1ps
// bmi_pkg: item types, codes and the control store of the byte machine interpreter
// no dependencies

package bmi_pkg;

    localparam int MEM_DEPTH = 256;
    localparam int ADDR_BITS = 8;
    localparam int DATA_BITS = 8;
    localparam int SC_BITS   = 20;
    localparam int UPC_BITS  = 3;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    localparam logic [2:0] OP_LDI  = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_LDX  = 3'd2;
    localparam logic [2:0] OP_STX  = 3'd3;
    localparam logic [2:0] OP_ADDZ = 3'd4;
    localparam logic [2:0] OP_SHL  = 3'd5;
    localparam logic [2:0] OP_SWAP = 3'd6;
    localparam logic [2:0] OP_XOR  = 3'd7;

    localparam logic [ADDR_BITS-1:0] ADDR_IP  = 8'd0;
    localparam logic [ADDR_BITS-1:0] ADDR_ONE = 8'd1;

    typedef struct packed {
        logic [1:0]           command;
        logic [ADDR_BITS-1:0] address;
        logic [DATA_BITS-1:0] data;
        logic [SC_BITS-1:0]   step_count;
    } t_item;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic [DATA_BITS-1:0] ip;
    } t_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_RUN,
        S_DONE
    } t_state;

    // read address source
    typedef enum logic [2:0] {
        RA_IP,
        RA_SRCA,
        RA_SRCB,
        RA_DST,
        RA_ADDR,
        RA_ONE
    } t_rasel;

    // register loaded from read data
    typedef enum logic [2:0] {
        LD_NONE,
        LD_INST,
        LD_A,
        LD_B,
        LD_D,
        LD_X,
        LD_Y
    } t_ldsel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_EXEC,
        WR_SWAP
    } t_wrsel;

    typedef struct packed {
        t_rasel ra;
        t_ldsel ld;
        t_wrsel wr;
        logic   end_ns;  // ends the instruction unless it is a swap
        logic   last;
    } t_uword;

    function automatic t_uword ucode(input logic [UPC_BITS-1:0] upc);
        t_uword w;
        w = '{ra: RA_IP, ld: LD_NONE, wr: WR_NONE, end_ns: 1'b0, last: 1'b0};
        case (upc)
            3'd0: w.ra = RA_IP;
            3'd1: begin
                w.ld = LD_INST;
                w.ra = RA_SRCA;
            end
            3'd2: begin
                w.ld = LD_A;
                w.ra = RA_SRCB;
            end
            3'd3: begin
                w.ld = LD_B;
                w.ra = RA_DST;
            end
            3'd4: begin
                w.ld = LD_D;
                w.ra = RA_ADDR;
            end
            3'd5: begin
                w.ld = LD_X;
                w.ra = RA_ONE;
            end
            3'd6: begin
                w.ld     = LD_Y;
                w.wr     = WR_EXEC;
                w.end_ns = 1'b1;
            end
            3'd7: begin
                w.wr   = WR_SWAP;
                w.last = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

endpackage

/* src/byte_machine_interpreter_top.sv */
`timescale 1ns / 1ps
// byte_machine_interpreter_top: 256-byte machine with a microcoded instruction sequencer
// depends on bmi_pkg
//
// channel   direction  handshake            payload
// command   in         start high, busy low i_item (t_item)
// result    out        o_valid, one cycle   o_result (t_result)
//
// after reset a clearing pass zeroes the memory, busy stays high until it ends
// write, read and unused commands give their result through the S_READ or S_DONE state and the result register
// run: each instruction steps through the microcode store, a swap takes an extra write step; the read port sets this
// the result register lets a new item start in the cycle its result is shown
// results cannot be stalled

module byte_machine_interpreter_top
    import bmi_pkg::*;
#(
    parameter int STEP_COUNT_BITS = 20
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_result
);

    logic [DATA_BITS-1:0] r_mem [MEM_DEPTH];
    logic [DATA_BITS-1:0] r_mq;
    logic                 r_rz;

    t_state                     r_state, n_state;
    logic [UPC_BITS-1:0]        r_upc;
    logic [STEP_COUNT_BITS-1:0] r_steps;
    logic [ADDR_BITS-1:0]       r_clr;
    logic [DATA_BITS-1:0]       r_ip, n_ip;
    logic [DATA_BITS-1:0]       r_inst, r_a, r_b, r_d, r_x, r_y;
    logic                       r_valid;
    t_result                    r_res;

    t_uword               w;
    logic [DATA_BITS-1:0] rd, inst_now, ip_base, sum;
    logic [2:0]           op;
    logic [ADDR_BITS-1:0] dst, swap_n;
    logic                 mem_we, ip_inc, uend;
    logic [ADDR_BITS-1:0] waddr, raddr;
    logic [DATA_BITS-1:0] wdata;

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    assign rd       = r_rz ? r_ip : r_mq;
    assign w        = ucode(r_upc);
    assign inst_now = (w.ld == LD_INST) ? rd : r_inst;
    assign op       = r_inst[7:5];
    assign dst      = {6'd0, r_inst[4:3]};
    assign swap_n   = {4'd0, r_inst[3:0]};
    assign sum      = r_a + r_b;
    assign uend     = w.last || (w.end_ns && (op != OP_SWAP));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == ADDR_BITS'(MEM_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    case (i_item.command)
                        CMD_READ: n_state = S_READ;
                        CMD_RUN: begin
                            if (STEP_COUNT_BITS'(i_item.step_count) != '0) n_state = S_RUN;
                            else n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RUN: begin
                if (uend && (r_steps == STEP_COUNT_BITS'(1))) n_state = S_DONE;
            end
            S_READ:  n_state = S_IDLE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        waddr  = r_clr;
        wdata  = '0;
        raddr  = r_ip;
        ip_inc = 1'b0;
        case (r_state)
            S_CLEAR: mem_we = 1'b1;
            S_IDLE: begin
                raddr = i_item.address;
                if (start && (i_item.command == CMD_WRITE)) begin
                    mem_we = 1'b1;
                    waddr  = i_item.address;
                    wdata  = i_item.data;
                end
            end
            S_RUN: begin
                case (w.ra)
                    RA_IP:   raddr = r_ip;
                    RA_SRCA: raddr = {7'd0, inst_now[0]};
                    RA_SRCB: raddr = {6'd0, r_inst[2:1]};
                    RA_DST:  raddr = dst;
                    RA_ADDR: raddr = (op == OP_SWAP) ? swap_n : sum;
                    RA_ONE:  raddr = ADDR_ONE;
                    default: raddr = r_ip;
                endcase
                case (w.wr)
                    WR_EXEC: begin
                        mem_we = 1'b1;
                        waddr  = dst;
                        case (op)
                            OP_LDI: wdata = {4'd0, r_inst[3:0]};
                            OP_ADD: wdata = sum;
                            OP_LDX: wdata = r_x;
                            OP_STX: begin
                                waddr = sum;
                                wdata = r_d;
                            end
                            OP_ADDZ: begin
                                mem_we = (r_b == '0);
                                wdata  = r_d + r_a;
                            end
                            OP_SHL: wdata = DATA_BITS'(r_a << r_inst[2:1]);
                            OP_SWAP: begin
                                waddr = ADDR_ONE;
                                wdata = r_x;
                            end
                            OP_XOR:  wdata = r_a ^ r_b;
                            default: wdata = r_a ^ r_b;
                        endcase
                        ip_inc = (op != OP_SWAP);
                    end
                    WR_SWAP: begin
                        mem_we = 1'b1;
                        waddr  = swap_n;
                        wdata  = r_y;
                        ip_inc = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        ip_base = (mem_we && (waddr == ADDR_IP)) ? wdata : r_ip;
        n_ip    = ip_base + {7'd0, ip_inc};
    end

    // byte zero lives in r_ip, its memory entry is never used
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[waddr] <= wdata;
        r_mq <= r_mem[raddr];
        r_rz <= (raddr == ADDR_IP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_upc   <= '0;
            r_steps <= '0;
            r_ip    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ip    <= n_ip;
            r_valid <= (r_state == S_READ) || (r_state == S_DONE);
            if (r_state == S_CLEAR) r_clr <= r_clr + 8'd1;
            if ((r_state == S_IDLE) && start) begin
                r_upc   <= '0;
                r_steps <= STEP_COUNT_BITS'(i_item.step_count);
            end else if (r_state == S_RUN) begin
                if (uend) begin
                    r_upc   <= '0;
                    r_steps <= r_steps - STEP_COUNT_BITS'(1);
                end else begin
                    r_upc <= r_upc + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN) begin
            case (w.ld)
                LD_INST: r_inst <= rd;
                LD_A:    r_a    <= rd;
                LD_B:    r_b    <= rd;
                LD_D:    r_d    <= rd;
                LD_X:    r_x    <= rd;
                LD_Y:    r_y    <= rd;
                default: ;
            endcase
        end
        r_res.read_data <= (r_state == S_READ) ? rd : '0;
        r_res.ip        <= r_ip;
    end

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_READ || $past(r_state) == S_DONE))
        else $error("result without a finishing state");

    a_swap_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_upc == 3'd7) |-> (op == OP_SWAP))
        else $error("second write step outside a swap");

    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_steps != '0))
        else $error("running with no steps left");
`endif

endmodule
